@@ src/acvd_pkg.sv @@
// Package for the alignment column variant detector.
// Holds sizing constants, register indexes and the per-lane result type.
// No dependencies; every other file in src uses it by scoped names.
package acvd_pkg;

  // Sizing of the column datapath.
  localparam int LANES         = 8;
  localparam int LANE_INPUTS   = 8;
  localparam int POSITION_BITS = 16;
  localparam int IGNORE_SLOTS  = 4;
  localparam int REG_SLOTS     = 4;
  localparam int CHAR_BITS     = 8;
  localparam int POS_OUT_BITS  = 16;

  // Lanes that really exist and ignore slots that can take effect.
  localparam int NUM_LANES  = (LANES < LANE_INPUTS) ? LANES : LANE_INPUTS;
  localparam int USED_SLOTS = (IGNORE_SLOTS < REG_SLOTS) ? IGNORE_SLOTS : REG_SLOTS;

  // Configuration register widths and reset values.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [31:0] IGNORE_CODES_RESET   = 32'h002D_2E4E;
  localparam logic [2:0]  IGNORE_USED_RESET    = 3'd3;
  localparam logic [15:0] START_POSITION_RESET = 16'd0;
  localparam logic [3:0]  SEQUENCES_USED_RESET = 4'd8;

  // Saturation value of the running column position.
  localparam logic [POSITION_BITS-1:0] POSITION_MAX = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IGNORE_CODES   = 2'd0,
    REG_IGNORE_USED    = 2'd1,
    REG_START_POSITION = 2'd2,
    REG_SEQUENCES_USED = 2'd3
  } cfg_reg_t;

  // What one lane reports to the merge stage.
  typedef struct packed {
    logic                 keep;
    logic [CHAR_BITS-1:0] ch;
  } lane_info_t;

endpackage

@@ src/acvd_if.sv @@
// Channel interfaces of the alignment column variant detector.
// Column input, result output and configuration write; depends on acvd_pkg.
interface acvd_col_if;
  logic       valid;
  logic       ready;
  logic [7:0] lane0_char;
  logic [7:0] lane1_char;
  logic [7:0] lane2_char;
  logic [7:0] lane3_char;
  logic [7:0] lane4_char;
  logic [7:0] lane5_char;
  logic [7:0] lane6_char;
  logic [7:0] lane7_char;
  logic       final_column;

  modport source (
    output valid, lane0_char, lane1_char, lane2_char, lane3_char,
    output lane4_char, lane5_char, lane6_char, lane7_char, final_column,
    input  ready
  );
  modport sink (
    input  valid, lane0_char, lane1_char, lane2_char, lane3_char,
    input  lane4_char, lane5_char, lane6_char, lane7_char, final_column,
    output ready
  );
endinterface

interface acvd_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] column_position;
  logic [7:0]  first_seq_char;
  logic [7:0]  second_seq_char;
  logic        reported;
  logic        end_of_alignment;

  modport source (
    output valid, column_position, first_seq_char, second_seq_char,
    output reported, end_of_alignment,
    input  ready
  );
  modport sink (
    input  valid, column_position, first_seq_char, second_seq_char,
    input  reported, end_of_alignment,
    output ready
  );
endinterface

interface acvd_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [acvd_pkg::CFG_INDEX_BITS-1:0]   index;
  logic [acvd_pkg::CFG_DATA_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/alignment_column_variant_detect.sv @@
// Alignment column variant detector, top level. One column per beat enters, the
// lanes test each character against the ignore set, the merge stage flags a
// differing column, and one result beat leaves per column. Lanes and merge are
// combinational and feed the output register; a new column is taken every
// cycle while the result side keeps up, so the sustained rate is one column
// per clock. The position counter saturates and returns to zero after a final
// column. Configuration writes are always accepted and must be made while no
// column is in flight.
// Depends on acvd_pkg, acvd_if, acvd_lane and acvd_merge.
module alignment_column_variant_detect (
  input  logic           clk,
  input  logic           rst,
  acvd_col_if.sink       col_in,
  acvd_res_if.source     result_out,
  acvd_cfg_if.sink       cfg
);

  localparam int NumLanes = acvd_pkg::NUM_LANES;

  // Configuration registers.
  logic [31:0] ignore_codes;
  logic [2:0]  ignore_used;
  logic [15:0] start_position;
  logic [3:0]  sequences_used;

  logic [acvd_pkg::POSITION_BITS-1:0] position_count;
  logic [acvd_pkg::POSITION_BITS-1:0] position_next;

  logic [acvd_pkg::CHAR_BITS-1:0] lane_char [acvd_pkg::LANE_INPUTS];
  acvd_pkg::lane_info_t           lane_info [NumLanes];
  logic                           differs;
  logic                           col_accept;
  logic                           reported_next;

  assign cfg.ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_codes   <= acvd_pkg::IGNORE_CODES_RESET;
      ignore_used    <= acvd_pkg::IGNORE_USED_RESET;
      start_position <= acvd_pkg::START_POSITION_RESET;
      sequences_used <= acvd_pkg::SEQUENCES_USED_RESET;
    end else if (cfg.valid) begin
      case (acvd_pkg::cfg_reg_t'(cfg.index))
        acvd_pkg::REG_IGNORE_CODES:   ignore_codes   <= cfg.data[31:0];
        acvd_pkg::REG_IGNORE_USED:    ignore_used    <= cfg.data[2:0];
        acvd_pkg::REG_START_POSITION: start_position <= cfg.data[15:0];
        acvd_pkg::REG_SEQUENCES_USED: sequences_used <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // Gather the lane characters of the incoming beat.
  assign lane_char[0] = col_in.lane0_char;
  assign lane_char[1] = col_in.lane1_char;
  assign lane_char[2] = col_in.lane2_char;
  assign lane_char[3] = col_in.lane3_char;
  assign lane_char[4] = col_in.lane4_char;
  assign lane_char[5] = col_in.lane5_char;
  assign lane_char[6] = col_in.lane6_char;
  assign lane_char[7] = col_in.lane7_char;

  // One lane per sequence; lanes at or above sequences_used sit out.
  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    acvd_lane u_lane (
      .ch           (lane_char[i]),
      .active       (int'(sequences_used) > i),
      .ignore_codes (ignore_codes),
      .ignore_used  (ignore_used),
      .info         (lane_info[i])
    );
  end

  acvd_merge u_merge (
    .lanes   (lane_info),
    .differs (differs)
  );

  // Position of this column, held at its maximum once reached.
  assign position_next = (position_count != acvd_pkg::POSITION_MAX) ?
                         position_count + 1'b1 : position_count;
  assign reported_next = differs && (32'(position_next) >= 32'(start_position));

  // The output register frees up whenever its beat is taken.
  assign col_in.ready = !result_out.valid || result_out.ready;
  assign col_accept   = col_in.valid && col_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count   <= '0;
      result_out.valid <= 1'b0;
    end else if (col_accept) begin
      position_count   <= col_in.final_column ? '0 : position_next;
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (col_accept) begin
      result_out.column_position  <= acvd_pkg::POS_OUT_BITS'(position_next);
      result_out.first_seq_char   <= col_in.lane0_char;
      result_out.second_seq_char  <= col_in.lane1_char;
      result_out.reported         <= reported_next;
      result_out.end_of_alignment <= col_in.final_column;
    end
  end

endmodule

@@ src/acvd_lane.sv @@
// One comparison lane: decides whether its character takes part in the column.
// Depends on acvd_pkg for widths and the lane result type.
module acvd_lane (
  input  logic [acvd_pkg::CHAR_BITS-1:0] ch,
  input  logic                           active,
  input  logic [31:0]                    ignore_codes,
  input  logic [2:0]                     ignore_used,
  output acvd_pkg::lane_info_t           info
);

  logic ignored;

  // Match the character against every slot that is in use.
  always_comb begin
    ignored = 1'b0;
    for (int k = 0; k < acvd_pkg::USED_SLOTS; k++) begin
      if ((int'(ignore_used) > k) && (ignore_codes[8*k +: 8] == ch)) begin
        ignored = 1'b1;
      end
    end
  end

  assign info.keep = active && !ignored;
  assign info.ch   = ch;

endmodule

@@ src/acvd_merge.sv @@
// Merge stage: combines the lane results into the column's differ flag.
// Depends on acvd_pkg for the lane count and the lane result type.
module acvd_merge (
  input  acvd_pkg::lane_info_t lanes [acvd_pkg::NUM_LANES],
  output logic                 differs
);

  // Two distinct kept characters exist exactly when some kept pair differs.
  always_comb begin
    differs = 1'b0;
    for (int i = 0; i < acvd_pkg::NUM_LANES; i++) begin
      for (int j = i + 1; j < acvd_pkg::NUM_LANES; j++) begin
        if (lanes[i].keep && lanes[j].keep && (lanes[i].ch != lanes[j].ch)) begin
          differs = 1'b1;
        end
      end
    end
  end

endmodule
